@@ hdl/tmrdiv_pkg.sv @@
package tmrdiv_pkg;

   // Timing constants
   localparam int DIVIDER_PERIOD  = 256;
   localparam int MAX_TICK_CYCLES = 16;

   // Field widths
   localparam int ADDR_W    = 16;
   localparam int DATA_W    = 8;
   localparam int CYC_W     = 5;
   localparam int DIV_REM_W = $clog2(DIVIDER_PERIOD + 1);
   localparam int PERIOD_W  = 11;

   // Register map
   localparam logic [ADDR_W-1:0] ADDR_DIV = 16'hff04;
   localparam logic [ADDR_W-1:0] ADDR_CNT = 16'hff05;
   localparam logic [ADDR_W-1:0] ADDR_MOD = 16'hff06;
   localparam logic [ADDR_W-1:0] ADDR_CTL = 16'hff07;

   // Control byte fields
   localparam int CTL_ENABLE_BIT = 2;
   localparam logic [DATA_W-1:0] COUNTER_TOP = 8'hff;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   // Counter period selected by control bits 1:0
   function automatic logic [PERIOD_W-1:0] period_of(input logic [1:0] sel);
      logic [PERIOD_W-1:0] p;
      case (sel)
         2'd0:    p = PERIOD_W'(1024);
         2'd1:    p = PERIOD_W'(16);
         2'd2:    p = PERIOD_W'(64);
         default: p = PERIOD_W'(256);
      endcase
      return p;
   endfunction

endpackage

@@ hdl/timer_divider_register_block_unit.sv @@
// Throughput: one word per cycle unless rsp_tready is low with a response pending;
// the input register and the response register are separated by one level of
// compare/subtract logic that also updates state.
// Reset (synchronous, active high): divider and counter cleared, divider period
// restarted in full, counter disabled with the period of control select 0.
module timer_divider_register_block_unit
   import tmrdiv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // address[15:0], write_data[23:16], cycles_elapsed[28:24]
   input  logic [1:0]  req_tuser,  // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // read_data[7:0], timer_irq[8]
);

   // Input register
   logic                  in_valid_ff;
   opcode_type            in_op_ff;
   logic [ADDR_W-1:0]     in_addr_ff;
   logic [DATA_W-1:0]     in_wdata_ff;
   logic [CYC_W-1:0]      in_cyc_ff;

   // Timer state
   logic [DATA_W-1:0]     div_val_ff,  div_val_in;
   logic [DIV_REM_W-1:0]  div_rem_ff,  div_rem_in;
   logic [DATA_W-1:0]     cnt_val_ff,  cnt_val_in;
   logic [DATA_W-1:0]     reload_ff,   reload_in;
   logic [DATA_W-1:0]     ctl_ff,      ctl_in;
   logic                  cnt_en_ff,   cnt_en_in;
   logic [PERIOD_W-1:0]   period_ff,   period_in;
   logic [PERIOD_W-1:0]   cnt_rem_ff,  cnt_rem_in;

   // Response register
   logic                  rsp_valid_ff;
   logic [DATA_W-1:0]     rsp_rdata_ff, rsp_rdata_in;
   logic                  rsp_irq_ff,   rsp_irq_in;

   logic                  advance;
   logic [CYC_W-1:0]      n_sat;
   logic [DIV_REM_W-1:0]  n_div;
   logic [PERIOD_W-1:0]   n_cnt;

   // Move a word forward when the response slot is free or being drained
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_irq_ff, rsp_rdata_ff};

   // Saturate the tick length
   assign n_sat = (in_cyc_ff > CYC_W'(MAX_TICK_CYCLES)) ? CYC_W'(MAX_TICK_CYCLES) : in_cyc_ff;
   assign n_div = DIV_REM_W'(n_sat);
   assign n_cnt = PERIOD_W'(n_sat);

   // Execute the registered word against the timer state
   always_comb begin
      div_val_in   = div_val_ff;
      div_rem_in   = div_rem_ff;
      cnt_val_in   = cnt_val_ff;
      reload_in    = reload_ff;
      ctl_in       = ctl_ff;
      cnt_en_in    = cnt_en_ff;
      period_in    = period_ff;
      cnt_rem_in   = cnt_rem_ff;
      rsp_rdata_in = '0;
      rsp_irq_in   = 1'b0;

      unique case (in_op_ff)
         OP_READ: begin
            if (in_addr_ff == ADDR_DIV) begin
               rsp_rdata_in = div_val_ff;
            end else if (in_addr_ff == ADDR_CNT) begin
               rsp_rdata_in = cnt_val_ff;
            end else if (in_addr_ff == ADDR_MOD) begin
               rsp_rdata_in = reload_ff;
            end else if (in_addr_ff == ADDR_CTL) begin
               rsp_rdata_in = ctl_ff;
            end
         end
         OP_WRITE: begin
            if (in_addr_ff == ADDR_DIV) begin
               div_val_in = '0;
            end else if (in_addr_ff == ADDR_CNT) begin
               cnt_val_in = in_wdata_ff;
            end else if (in_addr_ff == ADDR_MOD) begin
               reload_in = in_wdata_ff;
            end else if (in_addr_ff == ADDR_CTL) begin
               // restart the counter period on any control write
               ctl_in     = in_wdata_ff;
               cnt_en_in  = in_wdata_ff[CTL_ENABLE_BIT];
               period_in  = period_of(in_wdata_ff[1:0]);
               cnt_rem_in = period_of(in_wdata_ff[1:0]);
            end
         end
         OP_TICK: begin
            // divider: carry leftover cycles into the next period
            if (div_rem_ff > n_div) begin
               div_rem_in = div_rem_ff - n_div;
            end else begin
               div_val_in = div_val_ff + DATA_W'(1);
               div_rem_in = DIV_REM_W'(DIVIDER_PERIOD) + div_rem_ff - n_div;
            end
            // counter: step, reload past the top and flag the overflow
            if (cnt_en_ff) begin
               if (cnt_rem_ff > n_cnt) begin
                  cnt_rem_in = cnt_rem_ff - n_cnt;
               end else begin
                  if (cnt_val_ff == COUNTER_TOP) begin
                     cnt_val_in = reload_ff;
                     rsp_irq_in = 1'b1;
                  end else begin
                     cnt_val_in = cnt_val_ff + DATA_W'(1);
                  end
                  cnt_rem_in = period_ff + cnt_rem_ff - n_cnt;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control and timer state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_val_ff   <= '0;
         div_rem_ff   <= DIV_REM_W'(DIVIDER_PERIOD);
         cnt_val_ff   <= '0;
         reload_ff    <= '0;
         ctl_ff       <= '0;
         cnt_en_ff    <= 1'b0;
         period_ff    <= PERIOD_W'(1024);
         cnt_rem_ff   <= PERIOD_W'(1024);
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            div_val_ff   <= div_val_in;
            div_rem_ff   <= div_rem_in;
            cnt_val_ff   <= cnt_val_in;
            reload_ff    <= reload_in;
            ctl_ff       <= ctl_in;
            cnt_en_ff    <= cnt_en_in;
            period_ff    <= period_in;
            cnt_rem_ff   <= cnt_rem_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff    <= opcode_type'(req_tuser);
         in_addr_ff  <= req_tdata[15:0];
         in_wdata_ff <= req_tdata[23:16];
         in_cyc_ff   <= req_tdata[28:24];
      end
      if (advance) begin
         rsp_rdata_ff <= rsp_rdata_in;
         rsp_irq_ff   <= rsp_irq_in;
      end
   end

endmodule
